/* src/stok_pkg.sv */
// Shared types, token codes and keyword lookup for the source tokenizer.
// Depends on nothing; every file that uses it refers to it by scoped names.
package stok_pkg;

  localparam int MAX_IDENT_CHARS_DEF  = 8;
  localparam int MAX_COMMENT_NEST_DEF = 7;
  localparam int NUM_DIGITS_MAX       = 8;
  localparam int QUEUE_DEPTH          = 4;
  localparam int SLOTS                = 3;

  localparam logic [5:0] K_IDENT   = 6'd0;
  localparam logic [5:0] K_NUMBER  = 6'd1;
  localparam logic [5:0] K_CONST   = 6'd2;
  localparam logic [5:0] K_IF      = 6'd3;
  localparam logic [5:0] K_ELSE    = 6'd4;
  localparam logic [5:0] K_INT     = 6'd5;
  localparam logic [5:0] K_BOOL    = 6'd6;
  localparam logic [5:0] K_WHILE   = 6'd7;
  localparam logic [5:0] K_WRITE   = 6'd8;
  localparam logic [5:0] K_READ    = 6'd9;
  localparam logic [5:0] K_TRUE    = 6'd10;
  localparam logic [5:0] K_FALSE   = 6'd11;
  localparam logic [5:0] K_PLUS    = 6'd12;
  localparam logic [5:0] K_MINUS   = 6'd13;
  localparam logic [5:0] K_TIMES   = 6'd14;
  localparam logic [5:0] K_SLASH   = 6'd15;
  localparam logic [5:0] K_MOD     = 6'd16;
  localparam logic [5:0] K_XOR     = 6'd17;
  localparam logic [5:0] K_LSS     = 6'd18;
  localparam logic [5:0] K_LEQ     = 6'd19;
  localparam logic [5:0] K_GTR     = 6'd20;
  localparam logic [5:0] K_GEQ     = 6'd21;
  localparam logic [5:0] K_BECOMES = 6'd22;
  localparam logic [5:0] K_EQL     = 6'd23;
  localparam logic [5:0] K_NOT     = 6'd24;
  localparam logic [5:0] K_NEQ     = 6'd25;
  localparam logic [5:0] K_AND     = 6'd26;
  localparam logic [5:0] K_LAND    = 6'd27;
  localparam logic [5:0] K_OR      = 6'd28;
  localparam logic [5:0] K_LOR     = 6'd29;
  localparam logic [5:0] K_LPAREN  = 6'd30;
  localparam logic [5:0] K_RPAREN  = 6'd31;
  localparam logic [5:0] K_LBRACE  = 6'd32;
  localparam logic [5:0] K_RBRACE  = 6'd33;
  localparam logic [5:0] K_COMMA   = 6'd34;
  localparam logic [5:0] K_PERIOD  = 6'd35;
  localparam logic [5:0] K_SEMI    = 6'd36;
  localparam logic [5:0] K_END     = 6'd37;
  localparam logic [5:0] K_UNKNOWN = 6'd38;
  localparam logic [5:0] K_RCLOSE  = 6'd39;

  typedef struct packed {
    logic [5:0]  kind;
    logic [26:0] value;
    logic [63:0] chars;
    logic [3:0]  len;
    logic        ovf;
  } token_t;

  // Up to three tokens caused by one character, in order.
  typedef struct packed {
    token_t [SLOTS-1:0] slot;
    logic [1:0]         cnt;
  } group_t;

  function automatic token_t simple_tok(input logic [5:0] kind);
    token_t t;
    t = '0;
    t.kind = kind;
    return t;
  endfunction

  // Keyword match on the kept text; bytes past the count are zero.
  function automatic token_t ident_tok(input logic [63:0] buf_v, input logic [3:0] cnt);
    token_t t;
    t = '0;
    if      (cnt == 4'd5 && buf_v == 64'h74736E6F63) t.kind = K_CONST;
    else if (cnt == 4'd2 && buf_v == 64'h6669)       t.kind = K_IF;
    else if (cnt == 4'd4 && buf_v == 64'h65736C65)   t.kind = K_ELSE;
    else if (cnt == 4'd3 && buf_v == 64'h746E69)     t.kind = K_INT;
    else if (cnt == 4'd4 && buf_v == 64'h6C6F6F62)   t.kind = K_BOOL;
    else if (cnt == 4'd5 && buf_v == 64'h656C696877) t.kind = K_WHILE;
    else if (cnt == 4'd5 && buf_v == 64'h6574697277) t.kind = K_WRITE;
    else if (cnt == 4'd4 && buf_v == 64'h64616572)   t.kind = K_READ;
    else if (cnt == 4'd4 && buf_v == 64'h65757274) begin
      t.kind  = K_TRUE;
      t.value = 27'd1;
    end else if (cnt == 4'd5 && buf_v == 64'h65736C6166) t.kind = K_FALSE;
    else begin
      t.kind  = K_IDENT;
      t.chars = buf_v;
      t.len   = cnt;
    end
    return t;
  endfunction

endpackage

/* src/stok_if.sv */
// Valid/ready channel interfaces for characters in and tokens out.
// Depends on nothing.
interface stok_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_input;
  modport source (output valid, ch, end_of_input, input ready);
  modport sink (input valid, ch, end_of_input, output ready);
endinterface

interface stok_token_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [26:0] number_value;
  logic [63:0] ident_chars;
  logic [3:0]  ident_length;
  logic        overflow_flag;
  logic        last_of_run;
  modport source (output valid, token_kind, number_value, ident_chars, ident_length,
                  overflow_flag, last_of_run, input ready);
  modport sink (input valid, token_kind, number_value, ident_chars, ident_length,
                overflow_flag, last_of_run, output ready);
endinterface

/* src/source_tokenizer_unit.sv */
// Top level of the source tokenizer: front scanner, group queue, token emitter.
// Depends on stok_pkg, stok_if, stok_front, stok_queue and stok_back.
//
// Usage:
//   chars  - one source byte per item (ch, end_of_input), valid/ready.
//   tokens - one token per item; last_of_run marks the last token that a
//            given character caused (a character causes zero to three).
// The front takes one character per cycle and resolves all its tokens in that
// same cycle; a character that causes tokens pushes one group into a
// four-entry queue. The back presents the tokens of the head group one per
// cycle from registers. A group goes through the queue and then the back's
// group register. Throughput: one character per cycle while the queue has
// room; the token port sets the long-run rate at one token per cycle.
// When the token receiver stalls, the queue fills and then chars.ready drops;
// nothing is lost. Reset clears scanner state, queue and emitter: no token is
// shown in the cycle after reset. end_of_input flushes the pending token,
// appends an end token and returns the scanner to its reset state.
module source_tokenizer_unit #(
  parameter int MAX_IDENT_CHARS  = stok_pkg::MAX_IDENT_CHARS_DEF,
  parameter int MAX_COMMENT_NEST = stok_pkg::MAX_COMMENT_NEST_DEF
) (
  input  logic         clk,
  input  logic         rst,
  stok_char_if.sink    chars,
  stok_token_if.source tokens
);
  // Group handoff between front and back.
  logic             push, q_full, pop, q_nonempty;
  stok_pkg::group_t wgroup, rgroup;

  // Classify and accumulate; drop whitespace and comments here.
  stok_front #(
    .MAX_IDENT_CHARS  (MAX_IDENT_CHARS),
    .MAX_COMMENT_NEST (MAX_COMMENT_NEST)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars),
    .q_full (q_full),
    .push   (push),
    .group  (wgroup)
  );

  // Hold groups so a stalled receiver does not stop the scanner at once.
  stok_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wdata    (wgroup),
    .full     (q_full),
    .pop      (pop),
    .nonempty (q_nonempty),
    .rdata    (rgroup)
  );

  // Advance through each group one token per accepted transfer.
  stok_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_data     (rgroup),
    .pop        (pop),
    .tokens     (tokens)
  );

endmodule

/* src/stok_front.sv */
// Scanner front: classify one character per cycle while the queue has room and build its token group.
// Depends on stok_pkg and stok_char_if.
module stok_front #(
  parameter int MAX_IDENT_CHARS  = stok_pkg::MAX_IDENT_CHARS_DEF,
  parameter int MAX_COMMENT_NEST = stok_pkg::MAX_COMMENT_NEST_DEF
) (
  input  logic              clk,
  input  logic              rst,
  stok_char_if.sink         chars,
  input  logic              q_full,
  output logic              push,
  output stok_pkg::group_t  group
);
  localparam int DW = $clog2(MAX_COMMENT_NEST + 1);

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_NUM, M_LT, M_EQ, M_GT, M_BANG, M_AMP, M_BAR,
    M_SLASH, M_STAR, M_CMT, M_CMT_STAR, M_CMT_SLASH
  } mode_t;

  typedef struct packed {
    mode_t      mode;
    logic       lca;
    logic       start_ident;
    logic       start_num;
    logic       emit;
    logic [5:0] kind;
  } idle_res_t;

  mode_t       mode, mode_next;
  logic [63:0] ibuf, ibuf_next;
  logic [3:0]  icnt, icnt_next;
  logic [26:0] acc, acc_next;
  logic [3:0]  dcnt, dcnt_next;
  logic [DW-1:0] depth, depth_next;
  logic        lca, lca_next;

  logic [7:0]  c;
  logic        fire, rescan;
  idle_res_t   sc;
  stok_pkg::token_t [3:0] cand;
  logic [3:0]  cv;
  logic [2:0]  k;

  function automatic logic is_alpha(input logic [7:0] x);
    return (x >= "a" && x <= "z") || (x >= "A" && x <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] x);
    return x >= "0" && x <= "9";
  endfunction

  function automatic idle_res_t idle_scan(input logic [7:0] x, input logic lc);
    idle_res_t r;
    r = '0;
    r.mode = M_IDLE;
    if (lc) begin
      r.lca = (x != 8'h0A);
    end else if (x == " " || (x >= 8'd9 && x <= 8'd13)) begin
      r.lca = 1'b0;
    end else if (is_alpha(x)) begin
      r.mode = M_IDENT;
      r.start_ident = 1'b1;
    end else if (is_digit(x)) begin
      r.mode = M_NUM;
      r.start_num = 1'b1;
    end else begin
      r.emit = 1'b1;
      case (x)
        "<": begin r.mode = M_LT; r.emit = 1'b0; end
        "=": begin r.mode = M_EQ; r.emit = 1'b0; end
        ">": begin r.mode = M_GT; r.emit = 1'b0; end
        "!": begin r.mode = M_BANG; r.emit = 1'b0; end
        "&": begin r.mode = M_AMP; r.emit = 1'b0; end
        "|": begin r.mode = M_BAR; r.emit = 1'b0; end
        "/": begin r.mode = M_SLASH; r.emit = 1'b0; end
        "*": begin r.mode = M_STAR; r.emit = 1'b0; end
        "+": r.kind = stok_pkg::K_PLUS;
        "-": r.kind = stok_pkg::K_MINUS;
        "(": r.kind = stok_pkg::K_LPAREN;
        ")": r.kind = stok_pkg::K_RPAREN;
        "{": r.kind = stok_pkg::K_LBRACE;
        "}": r.kind = stok_pkg::K_RBRACE;
        ",": r.kind = stok_pkg::K_COMMA;
        ".": r.kind = stok_pkg::K_PERIOD;
        ";": r.kind = stok_pkg::K_SEMI;
        "%": r.kind = stok_pkg::K_MOD;
        "^": r.kind = stok_pkg::K_XOR;
        default: r.kind = stok_pkg::K_UNKNOWN;
      endcase
    end
    return r;
  endfunction

  function automatic stok_pkg::token_t num_tok(input logic [26:0] a, input logic [3:0] d);
    stok_pkg::token_t t;
    t = stok_pkg::simple_tok(stok_pkg::K_NUMBER);
    if (d > 4'(stok_pkg::NUM_DIGITS_MAX)) t.ovf = 1'b1;
    else t.value = a;
    return t;
  endfunction

  assign c           = chars.ch;
  assign chars.ready = !q_full && !rst;
  assign fire        = chars.valid && chars.ready;

  always_comb begin
    mode_next  = mode;
    ibuf_next  = ibuf;
    icnt_next  = icnt;
    acc_next   = acc;
    dcnt_next  = dcnt;
    depth_next = depth;
    lca_next   = lca;
    cand       = '0;
    cv         = '0;
    rescan     = 1'b0;
    sc         = idle_scan(c, lca);
    group      = '0;
    k          = '0;

    case (mode)
      M_IDENT: begin
        if (is_alpha(c) || is_digit(c)) begin
          if (icnt < 4'(MAX_IDENT_CHARS)) begin
            ibuf_next = ibuf | (64'(c) << {icnt[2:0], 3'b000});
            icnt_next = icnt + 4'd1;
          end
        end else begin
          cand[0] = stok_pkg::ident_tok(ibuf, icnt);
          cv[0]   = 1'b1;
          rescan  = 1'b1;
        end
      end
      M_NUM: begin
        if (is_digit(c)) begin
          if (dcnt < 4'(stok_pkg::NUM_DIGITS_MAX))
            acc_next = (acc << 3) + (acc << 1) + 27'(c - "0");
          if (dcnt < 4'd9) dcnt_next = dcnt + 4'd1;
        end else begin
          cand[0] = num_tok(acc, dcnt);
          cv[0]   = 1'b1;
          rescan  = 1'b1;
        end
      end
      M_LT, M_EQ, M_GT, M_BANG, M_AMP, M_BAR, M_STAR: begin
        cv[0] = 1'b1;
        if ((mode == M_AMP && c == "&") || (mode == M_BAR && c == "|") ||
            (mode == M_STAR && c == "/") ||
            (c == "=" && mode != M_AMP && mode != M_BAR && mode != M_STAR)) begin
          mode_next = M_IDLE;
          case (mode)
            M_LT:    cand[0] = stok_pkg::simple_tok(stok_pkg::K_LEQ);
            M_EQ:    cand[0] = stok_pkg::simple_tok(stok_pkg::K_EQL);
            M_GT:    cand[0] = stok_pkg::simple_tok(stok_pkg::K_GEQ);
            M_BANG:  cand[0] = stok_pkg::simple_tok(stok_pkg::K_NEQ);
            M_AMP:   cand[0] = stok_pkg::simple_tok(stok_pkg::K_LAND);
            M_BAR:   cand[0] = stok_pkg::simple_tok(stok_pkg::K_LOR);
            default: cand[0] = stok_pkg::simple_tok(stok_pkg::K_RCLOSE);
          endcase
        end else begin
          rescan = 1'b1;
          case (mode)
            M_LT:    cand[0] = stok_pkg::simple_tok(stok_pkg::K_LSS);
            M_EQ:    cand[0] = stok_pkg::simple_tok(stok_pkg::K_BECOMES);
            M_GT:    cand[0] = stok_pkg::simple_tok(stok_pkg::K_GTR);
            M_BANG:  cand[0] = stok_pkg::simple_tok(stok_pkg::K_NOT);
            M_AMP:   cand[0] = stok_pkg::simple_tok(stok_pkg::K_AND);
            M_BAR:   cand[0] = stok_pkg::simple_tok(stok_pkg::K_OR);
            default: cand[0] = stok_pkg::simple_tok(stok_pkg::K_TIMES);
          endcase
        end
      end
      M_SLASH: begin
        if (c == "*") begin
          mode_next  = M_CMT;
          depth_next = DW'(1);
        end else if (c == "/") begin
          mode_next = M_IDLE;
          lca_next  = 1'b1;
        end else begin
          cand[0] = stok_pkg::simple_tok(stok_pkg::K_SLASH);
          cv[0]   = 1'b1;
          rescan  = 1'b1;
        end
      end
      M_CMT: begin
        if (c == "*") mode_next = M_CMT_STAR;
        else if (c == "/") mode_next = M_CMT_SLASH;
      end
      M_CMT_STAR: begin
        if (c == "/") begin
          if (depth <= DW'(1)) begin
            depth_next = '0;
            mode_next  = M_IDLE;
          end else begin
            depth_next = depth - DW'(1);
            mode_next  = M_CMT;
          end
        end else if (c != "*") begin
          mode_next = M_CMT;
        end
      end
      M_CMT_SLASH: begin
        if (c == "*") begin
          if (depth < DW'(MAX_COMMENT_NEST)) depth_next = depth + DW'(1);
          mode_next = M_CMT;
        end else if (c != "/") begin
          mode_next = M_CMT;
        end
      end
      default: rescan = 1'b1;
    endcase

    // A character seen in idle, or one that broke a token, is scanned from idle.
    if (rescan) begin
      mode_next = sc.mode;
      lca_next  = sc.lca;
      if (sc.start_ident) begin
        ibuf_next = 64'(c);
        icnt_next = 4'd1;
      end
      if (sc.start_num) begin
        acc_next  = 27'(c - "0");
        dcnt_next = 4'd1;
      end
      cv[1]   = sc.emit;
      cand[1] = stok_pkg::simple_tok(sc.kind);
    end

    // End of source: flush what is pending, add the end token, drop all state.
    if (chars.end_of_input) begin
      cv[2] = 1'b1;
      case (mode_next)
        M_IDENT: cand[2] = stok_pkg::ident_tok(ibuf_next, icnt_next);
        M_NUM:   cand[2] = num_tok(acc_next, dcnt_next);
        M_LT:    cand[2] = stok_pkg::simple_tok(stok_pkg::K_LSS);
        M_EQ:    cand[2] = stok_pkg::simple_tok(stok_pkg::K_BECOMES);
        M_GT:    cand[2] = stok_pkg::simple_tok(stok_pkg::K_GTR);
        M_BANG:  cand[2] = stok_pkg::simple_tok(stok_pkg::K_NOT);
        M_AMP:   cand[2] = stok_pkg::simple_tok(stok_pkg::K_AND);
        M_BAR:   cand[2] = stok_pkg::simple_tok(stok_pkg::K_OR);
        M_SLASH: cand[2] = stok_pkg::simple_tok(stok_pkg::K_SLASH);
        M_STAR:  cand[2] = stok_pkg::simple_tok(stok_pkg::K_TIMES);
        default: cv[2] = 1'b0;
      endcase
      cand[3]    = stok_pkg::simple_tok(stok_pkg::K_END);
      cv[3]      = 1'b1;
      mode_next  = M_IDLE;
      ibuf_next  = '0;
      icnt_next  = '0;
      acc_next   = '0;
      dcnt_next  = '0;
      depth_next = '0;
      lca_next   = 1'b0;
    end

    for (int i = 0; i < 4; i++) begin
      if (cv[i]) begin
        if (k < 3'(stok_pkg::SLOTS)) group.slot[k[1:0]] = cand[i];
        k = k + 3'd1;
      end
    end
    group.cnt = (k > 3'(stok_pkg::SLOTS)) ? 2'(stok_pkg::SLOTS) : k[1:0];
  end

  assign push = fire && (group.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= M_IDLE;
      ibuf  <= '0;
      icnt  <= '0;
      acc   <= '0;
      dcnt  <= '0;
      depth <= '0;
      lca   <= 1'b0;
    end else if (fire) begin
      mode  <= mode_next;
      ibuf  <= ibuf_next;
      icnt  <= icnt_next;
      acc   <= acc_next;
      dcnt  <= dcnt_next;
      depth <= depth_next;
      lca   <= lca_next;
    end
  end

endmodule

/* src/stok_queue.sv */
// Short FIFO of token groups between the scanner front and the emitter back.
// Depends on stok_pkg.
module stok_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  stok_pkg::group_t wdata,
  output logic             full,
  input  logic             pop,
  output logic             nonempty,
  output stok_pkg::group_t rdata
);
  localparam int AW = $clog2(stok_pkg::QUEUE_DEPTH);

  stok_pkg::group_t entry [stok_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [AW:0]   count;

  assign full     = (count == (AW+1)'(stok_pkg::QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign rdata    = entry[rptr];

  always_ff @(posedge clk) begin
    if (push) entry[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == AW'(stok_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr + AW'(1);
      if (pop)  rptr <= (rptr == AW'(stok_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr + AW'(1);
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

/* src/stok_back.sv */
// Emitter back: hold one token group and hand its tokens out one at a time.
// Depends on stok_pkg and stok_token_if.
module stok_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_nonempty,
  input  stok_pkg::group_t q_data,
  output logic             pop,
  stok_token_if.source     tokens
);
  stok_pkg::group_t grp;
  logic [1:0]       idx;
  logic             have;
  logic             last;
  stok_pkg::token_t cur;

  assign cur  = grp.slot[idx];
  assign last = (idx == grp.cnt - 2'd1);
  assign pop  = q_nonempty && (!have || (tokens.ready && last));

  assign tokens.valid         = have;
  assign tokens.token_kind    = cur.kind;
  assign tokens.number_value  = cur.value;
  assign tokens.ident_chars   = cur.chars;
  assign tokens.ident_length  = cur.len;
  assign tokens.overflow_flag = cur.ovf;
  assign tokens.last_of_run   = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
      idx  <= '0;
    end else if (pop) begin
      have <= 1'b1;
      idx  <= '0;
      grp  <= q_data;
    end else if (have && tokens.ready) begin
      if (last) have <= 1'b0;
      else idx <= idx + 2'd1;
    end
  end

endmodule

/* src/stok_checker.sv */
// Port-level checks for the source tokenizer, bound to the top level.
// Depends on stok_pkg and source_tokenizer_unit.
module stok_checker (
  input logic        clk,
  input logic        rst,
  input logic        t_valid,
  input logic        t_ready,
  input logic [5:0]  t_kind,
  input logic [26:0] t_value,
  input logic [63:0] t_chars,
  input logic [3:0]  t_len,
  input logic        t_ovf
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    t_valid && !t_ready |=> t_valid)
    else $error("token dropped while stalled");

  a_reset_quiet: assert property (@(posedge clk) $past(rst) |-> !t_valid)
    else $error("token shown right after reset");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    t_valid |-> t_kind <= stok_pkg::K_RCLOSE)
    else $error("token code out of range");

  a_ident_only: assert property (@(posedge clk) disable iff (rst)
    t_valid && t_kind != stok_pkg::K_IDENT |-> t_len == 4'd0 && t_chars == 64'd0)
    else $error("identifier text on a non-identifier token");

  a_ovf: assert property (@(posedge clk) disable iff (rst)
    t_valid && t_ovf |-> t_kind == stok_pkg::K_NUMBER && t_value == 27'd0)
    else $error("overflow on a token that is not a zero-valued number");
endmodule

bind source_tokenizer_unit stok_checker u_stok_checker (
  .clk     (clk),
  .rst     (rst),
  .t_valid (tokens.valid),
  .t_ready (tokens.ready),
  .t_kind  (tokens.token_kind),
  .t_value (tokens.number_value),
  .t_chars (tokens.ident_chars),
  .t_len   (tokens.ident_length),
  .t_ovf   (tokens.overflow_flag)
);
